[rtl/sivq_pkg.sv]
// sivq_pkg: shared types, widths and constants for the int8 vector quantizer.
// No dependencies; imported by every rtl module of the block.

package sivq_pkg;

	localparam int ROW_MAX_DEF   = 64;
	localparam int FRAC_BITS_DEF = 16;

	localparam int VAL_W   = 32;
	localparam int CNT_W   = 7;
	localparam int IDX_W   = 6;
	localparam int Q_W     = 8;
	localparam int SCALE_W = 41;

	localparam logic [SCALE_W-1:0] SCALE_MAX = {SCALE_W{1'b1}};
	localparam int SCALE_DIV  = 127;
	localparam int ROUND_BIAS = 63;
	localparam int QUANT_MAX  = 127;

	typedef struct packed {
		logic signed [VAL_W-1:0] value;
		logic                    last;
	} in_item_t;

	typedef struct packed {
		logic signed [Q_W-1:0] quantized;
		logic [IDX_W-1:0]      element_index;
		logic [SCALE_W-1:0]    row_scale;
		logic                  end_of_run;
		logic                  overflow;
	} result_t;

	// one finished vector handed from loader to emitter
	typedef struct packed {
		logic [VAL_W-1:0] max_abs;
		logic [CNT_W-1:0] count;
		logic             dropped;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic wr_bank;
		logic rd_bank;
	} queue_stat_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_SCALE,
		B_READ,
		B_LOAD,
		B_DIV
	} back_state_t;

	function automatic logic [VAL_W-1:0] magnitude(input logic [VAL_W-1:0] raw);
		return raw[VAL_W-1] ? (~raw + VAL_W'(1)) : raw;
	endfunction

endpackage

[rtl/sivq_front.sv]
// sivq_front: accepts elements, writes them to the current store bank and tracks
// max magnitude, count and drop flag; hands a job descriptor on the last element.
// Depends on sivq_pkg.

module sivq_front import sivq_pkg::*; #(
	parameter int ROW_MAX = ROW_MAX_DEF,
	localparam int AW = (ROW_MAX > 1) ? $clog2(ROW_MAX) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  in_item_t         item,
	input  queue_stat_t      qstat,
	output logic             busy,
	output logic             push,
	output job_t             job,
	output logic             wr_en,
	output logic [AW:0]      wr_addr,
	output logic [VAL_W-1:0] wr_data
);

	logic [CNT_W-1:0] count_q;
	logic [VAL_W-1:0] max_q;
	logic             drop_q;

	logic             accept;
	logic             room;
	logic [VAL_W-1:0] mag;
	logic [CNT_W-1:0] count_nx;
	logic [VAL_W-1:0] max_nx;
	logic             drop_nx;

	// both banks hold vectors still waiting to be emitted
	assign busy   = qstat.full;
	assign accept = start & ~busy;
	assign room   = count_q < CNT_W'(ROW_MAX);
	assign mag    = magnitude(item.value);

	always_comb begin
		count_nx = room ? count_q + CNT_W'(1) : count_q;
		max_nx   = (room && (mag > max_q)) ? mag : max_q;
		drop_nx  = drop_q | ~room;
	end

	assign wr_en   = accept & room;
	assign wr_addr = {qstat.wr_bank, count_q[AW-1:0]};
	assign wr_data = item.value;

	assign push = accept & item.last;
	assign job  = '{max_abs: max_nx, count: count_nx, dropped: drop_nx};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			max_q   <= '0;
			drop_q  <= 1'b0;
		end else if (accept) begin
			if (item.last) begin
				count_q <= '0;
				max_q   <= '0;
				drop_q  <= 1'b0;
			end else begin
				count_q <= count_nx;
				max_q   <= max_nx;
				drop_q  <= drop_nx;
			end
		end
	end

endmodule

[rtl/sivq_queue.sv]
// sivq_queue: two-entry job queue between loader and emitter; entry slot number
// doubles as the element store bank. Depends on sivq_pkg.

module sivq_queue import sivq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  job_t        job,
	input  logic        pop,
	output job_t        head,
	output queue_stat_t qstat
);

	job_t       slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] fill_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= 1'b0;
			rd_q   <= 1'b0;
			fill_q <= '0;
		end else begin
			wr_q <= wr_q ^ push;
			rd_q <= rd_q ^ pop;
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	assign head          = slot_q[rd_q];
	assign qstat.full    = fill_q == 2'd2;
	assign qstat.empty   = fill_q == 2'd0;
	assign qstat.wr_bank = wr_q;
	assign qstat.rd_bank = rd_q;

endmodule

[rtl/sivq_back.sv]
// sivq_back: element store (two banks) plus emitter: base-128 digit divide by 127 for
// the row scale, then an 8-step restoring divide per element. Depends on sivq_pkg.

module sivq_back import sivq_pkg::*; #(
	parameter int ROW_MAX   = ROW_MAX_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	localparam int AW = (ROW_MAX > 1) ? $clog2(ROW_MAX) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [AW:0]      wr_addr,
	input  logic [VAL_W-1:0] wr_data,
	input  job_t             head,
	input  queue_stat_t      qstat,
	output logic             pop,
	output logic             result_valid,
	output result_t          result
);

	localparam int SH    = VAL_W - FRAC_BITS;
	localparam int NUM_W = VAL_W + SH;
	localparam int DIG_N = (NUM_W + 6) / 7;
	localparam int PN_W  = DIG_N * 7;
	localparam int SCW   = (DIG_N > 1) ? $clog2(DIG_N) : 1;
	localparam int DEPTH = 2 ** (AW + 1);
	localparam int NQ_W  = VAL_W + Q_W;
	localparam int DS_W  = NQ_W + 1;

	logic [VAL_W-1:0] mem [DEPTH];
	logic [VAL_W-1:0] rd_data_q;
	logic [AW:0]      rd_addr;

	back_state_t state_q, state_nx;

	logic [PN_W-1:0]    num_q;
	logic [6:0]         srem_q;
	logic [PN_W-1:0]    quot_q;
	logic [SCW-1:0]     sc_cnt_q;
	logic [SCALE_W-1:0] scale_q;
	logic [IDX_W-1:0]   idx_q;
	logic [NQ_W-1:0]    nrem_q;
	logic [DS_W-1:0]    dsh_q;
	logic [Q_W-1:0]     qbits_q;
	logic               neg_q;
	logic [2:0]         bit_cnt_q;
	result_t            result_q;
	logic               result_valid_q;

	logic               load_job, sc_step, sc_last, ld_elem, div_step, div_last, emit;
	logic               last_elem;
	logic [6:0]         s_dig;
	logic [7:0]         s_t;
	logic               s_ge;
	logic [6:0]         s_rem_nx;
	logic [6:0]         q_dig;
	logic [PN_W-1:0]    quot_nx;
	logic [SCALE_W-1:0] scale_clamped;
	logic [VAL_W-1:0]   l_mag;
	logic               d_ge;
	logic [Q_W-1:0]     q_final;
	logic [Q_W-1:0]     q_clamp;
	logic [Q_W-1:0]     q_signed;

	// store: loader writes one bank while this side reads the other
	assign rd_addr = {qstat.rd_bank, idx_q[AW-1:0]};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign sc_last   = sc_cnt_q == SCW'(DIG_N - 1);
	assign div_last  = bit_cnt_q == 3'd0;
	assign last_elem = (CNT_W'(idx_q) + CNT_W'(1)) == head.count;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			B_IDLE:  if (!qstat.empty) state_nx = B_SCALE;
			B_SCALE: if (sc_last) state_nx = B_READ;
			B_READ:  state_nx = B_LOAD;
			B_LOAD:  state_nx = B_DIV;
			B_DIV:   if (div_last) state_nx = last_elem ? B_IDLE : B_READ;
			default: state_nx = B_IDLE;
		endcase
	end

	always_comb begin
		load_job = 1'b0;
		sc_step  = 1'b0;
		ld_elem  = 1'b0;
		div_step = 1'b0;
		case (state_q)
			B_IDLE:  load_job = !qstat.empty;
			B_SCALE: sc_step  = 1'b1;
			B_LOAD:  ld_elem  = 1'b1;
			B_DIV:   div_step = 1'b1;
			default: ;
		endcase
	end

	assign emit = div_step & div_last;
	assign pop  = emit & last_elem;

	// long division of (max_abs << SH) + 63 by 127, one base-128 digit per cycle;
	// with r < 127: (128*r + d) / 127 = r + ((r + d) >= 127)
	always_comb begin
		s_dig    = num_q[PN_W-1 -: 7];
		s_t      = {1'b0, srem_q} + {1'b0, s_dig};
		s_ge     = s_t >= 8'(SCALE_DIV);
		s_rem_nx = s_ge ? 7'(s_t - 8'(SCALE_DIV)) : s_t[6:0];
		q_dig    = srem_q + {6'd0, s_ge};
		quot_nx  = {quot_q[PN_W-8:0], q_dig};
		if (quot_nx == '0)
			scale_clamped = SCALE_W'(1);
		else if (quot_nx > PN_W'(SCALE_MAX))
			scale_clamped = SCALE_MAX;
		else
			scale_clamped = SCALE_W'(quot_nx);
	end

	// quotient of (254*|v| + m) / (2m) is below 128, so 8 steps suffice
	always_comb begin
		l_mag    = magnitude(rd_data_q);
		d_ge     = {1'b0, nrem_q} >= dsh_q;
		q_final  = {qbits_q[Q_W-2:0], d_ge};
		if (head.max_abs == '0)
			q_clamp = '0;
		else if (q_final > Q_W'(QUANT_MAX))
			q_clamp = Q_W'(QUANT_MAX);
		else
			q_clamp = q_final;
		q_signed = neg_q ? (Q_W'(0) - q_clamp) : q_clamp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= B_IDLE;
			sc_cnt_q       <= '0;
			bit_cnt_q      <= '0;
			idx_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q        <= state_nx;
			result_valid_q <= emit;
			if (load_job)
				sc_cnt_q <= '0;
			else if (sc_step)
				sc_cnt_q <= sc_cnt_q + SCW'(1);
			if (sc_step && sc_last)
				idx_q <= '0;
			else if (emit)
				idx_q <= idx_q + IDX_W'(1);
			if (ld_elem)
				bit_cnt_q <= 3'd7;
			else if (div_step)
				bit_cnt_q <= bit_cnt_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_job) begin
			num_q  <= (PN_W'(head.max_abs) << SH) + PN_W'(ROUND_BIAS);
			srem_q <= '0;
			quot_q <= '0;
		end else if (sc_step) begin
			num_q  <= num_q << 7;
			srem_q <= s_rem_nx;
			quot_q <= quot_nx;
			if (sc_last)
				scale_q <= scale_clamped;
		end
		if (ld_elem) begin
			nrem_q  <= (NQ_W'(l_mag) << 8) - (NQ_W'(l_mag) << 1) + NQ_W'(head.max_abs);
			dsh_q   <= DS_W'(head.max_abs) << 8;
			neg_q   <= rd_data_q[VAL_W-1];
			qbits_q <= '0;
		end else if (div_step) begin
			nrem_q  <= d_ge ? nrem_q - dsh_q[NQ_W-1:0] : nrem_q;
			dsh_q   <= dsh_q >> 1;
			qbits_q <= q_final;
		end
		if (emit) begin
			result_q <= '{quantized: q_signed, element_index: idx_q, row_scale: scale_q,
				end_of_run: last_elem, overflow: head.dropped};
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

[rtl/symmetric_int8_vector_quantizer.sv]
// Symmetric int8 vector quantizer, top level: loader, job queue, emitter.
// Depends on sivq_pkg, sivq_front, sivq_queue, sivq_back.
//
//   channel  | handshake            | payload
//   ---------+----------------------+---------------------------------
//   input    | start, busy          | item   (value, last)
//   result   | result_valid strobe  | result (quantized, element_index,
//            |                      |         row_scale, end_of_run, overflow)
//
// Loading takes one element per cycle while busy is low, into one of two store banks.
// Per vector the emitter takes the job, then runs the base-128 digit divide by 127
// for the scale, then works through the elements one at a time (store read, operand
// setup, 8 divide steps), each finishing before the next begins; one result per element.
// busy rises while both banks hold vectors not yet emitted, and drops when the
// emitter finishes one. Results cannot be stalled. No clearing pass after reset.

module symmetric_int8_vector_quantizer import sivq_pkg::*; #(
	parameter int ROW_MAX   = ROW_MAX_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  in_item_t item,
	output logic     busy,
	output logic     result_valid,
	output result_t  result
);

	localparam int AW = (ROW_MAX > 1) ? $clog2(ROW_MAX) : 1;

	queue_stat_t      qstat;
	job_t             job;
	job_t             head;
	logic             push;
	logic             pop;
	logic             wr_en;
	logic [AW:0]      wr_addr;
	logic [VAL_W-1:0] wr_data;

	sivq_front #(.ROW_MAX(ROW_MAX)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.item    (item),
		.qstat   (qstat),
		.busy    (busy),
		.push    (push),
		.job     (job),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	sivq_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.job    (job),
		.pop    (pop),
		.head   (head),
		.qstat  (qstat)
	);

	sivq_back #(.ROW_MAX(ROW_MAX), .FRAC_BITS(FRAC_BITS)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (wr_en),
		.wr_addr      (wr_addr),
		.wr_data      (wr_data),
		.head         (head),
		.qstat        (qstat),
		.pop          (pop),
		.result_valid (result_valid),
		.result       (result)
	);

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !qstat.full)
		else $error("job pushed into full queue");

	a_pop_job: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("job popped from empty queue");

	a_strobe_gap: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("back-to-back result strobes");

	a_quant_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.quantized != 8'h80))
		else $error("quantized value outside -127..127");

	a_scale_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.row_scale != '0))
		else $error("zero row scale");

endmodule

[tb/tb_symmetric_int8_vector_quantizer.sv]
// Testbench for symmetric_int8_vector_quantizer: loads vectors of Q16.16 elements, predicts
// the int8 codes and row scale of each vector and checks every result strobe in order.
// Depends on sivq_pkg and the rtl of the block; self-contained otherwise.
`timescale 1ns / 100ps

module tb_symmetric_int8_vector_quantizer;
	import sivq_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int TAIL_CYCLES    = 800;
	localparam int REPORT_MAX     = 10;

	logic     clk = 1'b0;
	logic     arst_n;
	logic     start;
	in_item_t item;
	logic     busy;
	logic     result_valid;
	result_t  result;

	symmetric_int8_vector_quantizer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.item         (item),
		.busy         (busy),
		.result_valid (result_valid),
		.result       (result)
	);

	always #5 clk = ~clk;

	// shadow of the loader state
	logic [VAL_W-1:0] row_buf [ROW_MAX_DEF];
	int unsigned      row_len;
	logic [VAL_W-1:0] row_peak;
	logic             row_dropped;

	result_t codes_due [$];
	result_t want_r;

	int idle_pct;
	int errors;
	int elems_sent;
	int vectors_sent;
	int results_checked;
	int overflow_vectors;
	int zero_vectors;
	int idle_cycles;

	function automatic logic [Q_W-1:0] quantize_element(logic [VAL_W-1:0] raw,
			logic [VAL_W-1:0] peak);
		logic [VAL_W-1:0] mag;
		logic [63:0]      q;
		if (peak == '0)
			return '0;
		mag = raw[VAL_W-1] ? (~raw + 32'd1) : raw;
		q = (64'(mag) * (2 * QUANT_MAX) + 64'(peak)) / (64'(peak) * 2);
		if (raw[VAL_W-1]) begin
			if (q > QUANT_MAX + 1)
				q = 64'(QUANT_MAX + 1);
			return Q_W'(-q);
		end
		if (q > QUANT_MAX)
			q = 64'(QUANT_MAX);
		return q[Q_W-1:0];
	endfunction

	function automatic logic [SCALE_W-1:0] vector_scale(logic [VAL_W-1:0] peak);
		logic [63:0] s;
		s = ((64'(peak) << (32 - FRAC_BITS_DEF)) + ROUND_BIAS) / SCALE_DIV;
		if (s == 0)
			s = 64'd1;
		if (s > 64'(SCALE_MAX))
			s = 64'(SCALE_MAX);
		return s[SCALE_W-1:0];
	endfunction

	// called on each accepted element; a last element releases the whole row
	function automatic void load_element(logic [VAL_W-1:0] raw, logic is_last);
		logic [VAL_W-1:0] mag;
		result_t          r;
		logic             all_zero;
		mag = raw[VAL_W-1] ? (~raw + 32'd1) : raw;
		if (row_len < ROW_MAX_DEF) begin
			row_buf[row_len] = raw;
			row_len++;
			if (mag > row_peak)
				row_peak = mag;
		end else begin
			row_dropped = 1'b1;
		end
		if (!is_last)
			return;
		all_zero = (row_peak == '0);
		for (int k = 0; k < row_len; k++) begin
			r.quantized     = quantize_element(row_buf[k], row_peak);
			r.element_index = IDX_W'(k);
			r.row_scale     = vector_scale(row_peak);
			r.end_of_run    = (k + 1 == row_len);
			r.overflow      = row_dropped;
			codes_due.push_back(r);
		end
		vectors_sent++;
		if (row_dropped)
			overflow_vectors++;
		if (all_zero)
			zero_vectors++;
		row_len     = 0;
		row_peak    = '0;
		row_dropped = 1'b0;
	endfunction

	function automatic void note_error(string what, result_t exp_r, result_t got_r);
		errors++;
		if (errors <= REPORT_MAX) begin
			$display("%0t mismatch (%s): exp q=%0d idx=%0d scale=%0d eor=%0b ovf=%0b",
				$realtime, what, exp_r.quantized, exp_r.element_index, exp_r.row_scale,
				exp_r.end_of_run, exp_r.overflow);
			$display("    got q=%0d idx=%0d scale=%0d eor=%0b ovf=%0b",
				got_r.quantized, got_r.element_index, got_r.row_scale,
				got_r.end_of_run, got_r.overflow);
		end
	endfunction

	// result checker: the block cannot be stalled, so every strobe is a transfer
	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			if (codes_due.size() == 0) begin
				note_error("no result pending", '0, result);
			end else begin
				want_r = codes_due.pop_front();
				results_checked++;
				if (result.quantized !== want_r.quantized)
					note_error("quantized", want_r, result);
				else if (result.element_index !== want_r.element_index)
					note_error("element_index", want_r, result);
				else if (result.row_scale !== want_r.row_scale)
					note_error("row_scale", want_r, result);
				else if (result.end_of_run !== want_r.end_of_run)
					note_error("end_of_run", want_r, result);
				else if (result.overflow !== want_r.overflow)
					note_error("overflow", want_r, result);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || result_valid) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles, %0d results pending",
					idle_cycles, codes_due.size());
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// entered and left at a falling edge; start stays high between back-to-back elements
	task automatic send_elem(input logic [VAL_W-1:0] v, input logic is_last);
		while ($urandom_range(0, 99) < idle_pct) begin
			start      = 1'b0;
			item.value = $urandom;
			item.last  = 1'($urandom_range(0, 1));
			@(negedge clk);
		end
		start      = 1'b1;
		item.value = v;
		item.last  = is_last;
		do @(posedge clk); while (busy);
		load_element(v, is_last);
		elems_sent++;
		@(negedge clk);
	endtask

	function automatic logic [VAL_W-1:0] pick_value(int mode);
		case (mode)
			0: return $urandom;
			1: return VAL_W'($signed($urandom_range(0, 600)) - 300);
			2: return '0;
			default: begin
				case ($urandom_range(0, 6))
					0: return 32'h7FFF_FFFF;
					1: return 32'h8000_0000;
					2: return '0;
					3: return 32'd1;
					4: return 32'hFFFF_FFFF;
					5: return $urandom >> 16;
					default: return $urandom;
				endcase
			end
		endcase
	endfunction

	task automatic send_vector(input int len, input int mode);
		for (int i = 0; i < len; i++)
			send_elem(pick_value(mode), i == len - 1);
	endtask

	task automatic wait_drained;
		start = 1'b0;
		while (codes_due.size() != 0)
			@(negedge clk);
	endtask

	task automatic send_list(input logic [VAL_W-1:0] vals [$]);
		foreach (vals[i])
			send_elem(vals[i], i == vals.size() - 1);
	endtask

	// zero rows, full-scale extremes, most negative peak, half-way ties, tiny peak
	task automatic test_extremes;
		idle_pct = 0;
		send_list('{32'd0});
		send_list('{32'd0, 32'd0, 32'd0});
		send_list('{32'h7FFF_FFFF, 32'h8000_0000, 32'd1, 32'hFFFF_FFFF, 32'd0});
		send_list('{32'h7FFF_FFFF});
		send_list('{32'd254, 32'd1, -32'sd1, 32'd3, -32'sd3, 32'd127});
		send_list('{32'd1});
		send_list('{-32'sd1, 32'd0});
	endtask

	// a row longer than the store (its last two elements are dropped), then one that
	// fills the store exactly
	task automatic test_store_overflow;
		idle_pct = 0;
		send_vector(ROW_MAX_DEF + 2, 0);
		idle_pct = 31;
		send_vector(ROW_MAX_DEF, 1);
	endtask

	// sender holds off until the block has emitted everything, then resumes
	task automatic test_drain_pause;
		idle_pct = 0;
		send_vector(5, 1);
		wait_drained();
		send_vector(3, 0);
		send_vector(2, 3);
		wait_drained();
	endtask

	task automatic test_random_vectors(input int pct, input int budget);
		int goal;
		int len;
		int mode;
		int r;
		idle_pct = pct;
		goal = elems_sent + budget;
		while (elems_sent < goal) begin
			r = $urandom_range(0, 99);
			if (r < 78)
				len = $urandom_range(1, 8);
			else if (r < 97)
				len = $urandom_range(9, 40);
			else
				len = $urandom_range(60, 70);
			r = $urandom_range(0, 9);
			mode = (r < 4) ? 0 : (r < 7) ? 1 : (r == 7) ? 2 : 3;
			send_vector(len, mode);
		end
	endtask

	initial begin
		arst_n           = 1'b0;
		start            = 1'b0;
		item             = '0;
		idle_pct         = 0;
		errors           = 0;
		elems_sent       = 0;
		vectors_sent     = 0;
		results_checked  = 0;
		overflow_vectors = 0;
		zero_vectors     = 0;
		idle_cycles      = 0;
		row_len          = 0;
		row_peak         = '0;
		row_dropped      = 1'b0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_extremes();
		test_store_overflow();
		test_drain_pause();
		test_random_vectors(0, 20);
		test_random_vectors(86, 20);
		test_random_vectors(31, 20);
		test_random_vectors(0, 10);

		wait_drained();
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("Sent %0d elements in %0d vectors; checked %0d results.",
			elems_sent, vectors_sent, results_checked);
		$display("Vectors past the store: %0d, all-zero vectors: %0d, errors: %0d.",
			overflow_vectors, zero_vectors, errors);
		if (errors == 0 && codes_due.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

[files.f]
rtl/sivq_pkg.sv
rtl/sivq_front.sv
rtl/sivq_queue.sv
rtl/sivq_back.sv
rtl/symmetric_int8_vector_quantizer.sv
tb/tb_symmetric_int8_vector_quantizer.sv
